// ----- hdl/bdcc_pkg.sv -----
// ----------------------------------------------------------------------------
// bdcc_pkg
// Shared types and constants of the button debounce and click coder.
// ----------------------------------------------------------------------------
package bdcc_pkg;

    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 16;

    localparam logic [CfgIndexWidth-1:0] CFG_BYTE_MODE        = 3'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_INVERT_INPUT     = 3'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_WATCHED_BIT      = 3'd2;
    localparam logic [CfgIndexWidth-1:0] CFG_SAMPLE_PERIOD_US = 3'd3;
    localparam logic [CfgIndexWidth-1:0] CFG_LONG_CLICK_MS    = 3'd4;
    localparam logic [CfgIndexWidth-1:0] CFG_MULTI_CLICK_MS   = 3'd5;

    localparam logic [15:0] RESET_SAMPLE_PERIOD_US = 16'd5000;
    localparam logic [15:0] RESET_LONG_CLICK_MS    = 16'd1000;
    localparam logic [15:0] RESET_MULTI_CLICK_MS   = 16'd400;

    // Reciprocal of 1000 scaled by 2^26, exact for any 16-bit dividend.
    localparam logic [16:0] RECIP_MS       = 17'd67109;
    localparam int          RECIP_SHIFT    = 26;
    localparam logic [9:0]  US_PER_MS      = 10'd1000;

    // 2^32 microseconds expressed as whole milliseconds and leftover microseconds.
    localparam logic [22:0] TIMER_WRAP_MS  = 23'd4294967;
    localparam logic [9:0]  TIMER_WRAP_US  = 10'd296;
    localparam logic [9:0]  WRAP_BORROW_US = 10'd704;

    localparam logic [7:0]  MULTI_MARKER   = 8'hF0;
    localparam logic [3:0]  NIBBLE_FULL    = 4'hF;
    localparam logic [7:0]  LONG_STEP      = 8'h10;
    localparam logic [2:0]  LONG_FULL      = 3'b111;
    localparam logic [7:0]  MULTI_LIMIT    = 8'hEF;

    typedef enum logic [2:0] {
        CLS_WAIT    = 3'd0,
        CLS_PRESS   = 3'd1,
        CLS_RELEASE = 3'd2,
        CLS_MULTI   = 3'd3,
        CLS_SHORT   = 3'd4,
        CLS_LONG    = 3'd5,
        CLS_DONE    = 3'd6
    } cls_state_t;

    typedef struct packed {
        logic        byte_mode;
        logic        invert_input;
        logic [2:0]  watched_bit;
        logic [6:0]  period_ms;
        logic [9:0]  period_rem_us;
        logic [15:0] long_click_ms;
        logic [15:0] multi_click_ms;
    } cfg_t;

    typedef struct packed {
        logic [7:0] debounced;
        logic       watched_level;
        logic       press_edge;
        logic       release_edge;
    } fe_item_t;

    typedef struct packed {
        logic [7:0]  click_code;
        logic        code_valid;
        logic [22:0] elapsed_ms;
        logic        release_seen;
        logic        press_seen;
        logic [7:0]  debounced_bits;
    } result_t;

endpackage

// ----- hdl/button_debounce_click_coder_core.sv -----
// ----------------------------------------------------------------------------
// button_debounce_click_coder_core
// Button sample debouncer with press/release events and a click coder.
//
//   channel   dir   fields (lowest bit first)
//   cfg       in    cfg_we, cfg_index, cfg_wdata
//   s_*       in    tdata: raw_sample
//   m_*       out   tdata: debounced_bits, press_seen, release_seen,
//                          elapsed_ms, code_valid, click_code
//
// A request is taken every cycle while the queue has room; results are registered.
// The queue between the sampling front and the coder holds QUEUE_DEPTH requests.
// A stalled output fills the queue, then s_tready drops until results are taken.
// Asynchronous reset clears the control state and loads the register defaults.
// ----------------------------------------------------------------------------
module button_debounce_click_coder_core
    import bdcc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [CfgDataWidth-1:0]  cfg_wdata,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // raw_sample[7:0]
    input  logic [7:0]               s_tdata,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // debounced_bits[7:0], press_seen[8], release_seen[9], elapsed_ms[32:10],
    // code_valid[33], click_code[41:34], zero[47:42]
    output logic [47:0]              m_tdata
);

    cfg_t        cfg_reg, cfg_next;
    logic [32:0] recip_prod;
    logic [6:0]  wr_ms;
    logic [16:0] wr_rem;

    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_valid;
    fe_item_t    fe_item;
    fe_item_t    be_item;
    result_t     result;

    always_comb
    begin
        cfg_next   = cfg_reg;
        recip_prod = {16'd0, cfg_wdata} * {16'd0, RECIP_MS};
        wr_ms      = recip_prod[RECIP_SHIFT +: 7];
        wr_rem     = {1'b0, cfg_wdata} - 17'({10'd0, wr_ms} * 17'(US_PER_MS));
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BYTE_MODE:        cfg_next.byte_mode      = cfg_wdata[0];
                CFG_INVERT_INPUT:     cfg_next.invert_input   = cfg_wdata[0];
                CFG_WATCHED_BIT:      cfg_next.watched_bit    = cfg_wdata[2:0];
                CFG_SAMPLE_PERIOD_US:
                begin
                    cfg_next.period_ms     = wr_ms;
                    cfg_next.period_rem_us = wr_rem[9:0];
                end
                CFG_LONG_CLICK_MS:    cfg_next.long_click_ms  = cfg_wdata;
                CFG_MULTI_CLICK_MS:   cfg_next.multi_click_ms = cfg_wdata;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.byte_mode      <= 1'b0;
            cfg_reg.invert_input   <= 1'b0;
            cfg_reg.watched_bit    <= '0;
            cfg_reg.period_ms      <= 7'(RESET_SAMPLE_PERIOD_US / US_PER_MS);
            cfg_reg.period_rem_us  <= 10'(RESET_SAMPLE_PERIOD_US % US_PER_MS);
            cfg_reg.long_click_ms  <= RESET_LONG_CLICK_MS;
            cfg_reg.multi_click_ms <= RESET_MULTI_CLICK_MS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bdcc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (fe_item)
    );

    bdcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (fe_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_item  (be_item)
    );

    bdcc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (be_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (result)
    );

    assign m_tdata = {6'd0, result};

    a_code_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && result.code_valid) |-> (result.click_code != '0))
        else $error("click code flagged valid but zero");

    a_edges_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(result.press_seen && result.release_seen))
        else $error("press and release in the same result");

    a_elapsed_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (result.elapsed_ms <= TIMER_WRAP_MS))
        else $error("elapsed milliseconds out of range");

    a_full_has_data: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> q_valid)
        else $error("input stalled while the queue is empty");

endmodule

// ----- hdl/bdcc_front.sv -----
// ----------------------------------------------------------------------------
// bdcc_front
// Accepts raw samples, runs the three-sample consensus and finds edges.
// ----------------------------------------------------------------------------
module bdcc_front
    import bdcc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       q_full,
    output logic       q_push,
    output fe_item_t   q_item
);

    logic [7:0] prev_reg, prev_next;
    logic [7:0] older_reg, older_next;
    logic [7:0] level_reg, level_next;
    logic [7:0] cur;
    logic [7:0] window;
    logic [7:0] all_high;
    logic [7:0] all_low;
    logic       old_w;
    logic       new_w;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb
    begin
        cur = cfg.byte_mode ? s_tdata : (s_tdata & 8'h03);
        if (cfg.invert_input)
        begin
            cur = ~cur;
        end
        window   = cfg.byte_mode ? (8'hFF << cfg.watched_bit) : (8'h03 << cfg.watched_bit);
        all_high = cur & prev_reg & older_reg & window;
        all_low  = ~cur & ~prev_reg & ~older_reg & window;
        level_next = (level_reg | all_high) & ~all_low;
        old_w = level_reg[cfg.watched_bit];
        new_w = level_next[cfg.watched_bit];
        prev_next  = cur;
        older_next = prev_reg;
        q_item.debounced     = level_next;
        q_item.watched_level = new_w;
        q_item.press_edge    = old_w && !new_w;
        q_item.release_edge  = !old_w && new_w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            older_reg <= '0;
            level_reg <= '0;
        end
        else if (q_push)
        begin
            prev_reg  <= prev_next;
            older_reg <= older_next;
            level_reg <= level_next;
        end
    end

endmodule

// ----- hdl/bdcc_queue.sv -----
// ----------------------------------------------------------------------------
// bdcc_queue
// Short first-in first-out queue between the sampling front and the coder.
// ----------------------------------------------------------------------------
module bdcc_queue
    import bdcc_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  fe_item_t push_item,
    output logic     full,
    input  logic     pop,
    output logic     not_empty,
    output fe_item_t pop_item
);

    localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntWidth = $clog2(DEPTH + 1);
    localparam logic [PtrWidth-1:0] LastPtr  = PtrWidth'(DEPTH - 1);
    localparam logic [CntWidth-1:0] FullCnt  = CntWidth'(DEPTH);

    fe_item_t            slot_reg [DEPTH];
    logic [PtrWidth-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrWidth-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntWidth-1:0] count_reg, count_next;

    assign full      = (count_reg == FullCnt);
    assign not_empty = (count_reg != '0);
    assign pop_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- hdl/bdcc_back.sv -----
// ----------------------------------------------------------------------------
// bdcc_back
// Millisecond timer, click classifier and the registered result stage.
// ----------------------------------------------------------------------------
module bdcc_back
    import bdcc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  cfg_t     cfg,
    input  logic     q_valid,
    input  fe_item_t q_item,
    output logic     q_pop,
    output logic     m_tvalid,
    input  logic     m_tready,
    output result_t  m_result
);

    cls_state_t  st_reg, st_next;
    logic        press_pend_reg, press_pend_next;
    logic        rel_pend_reg, rel_pend_next;
    logic [22:0] tms_reg, tms_next;
    logic [9:0]  trem_reg, trem_next;
    logic [22:0] held_reg, held_next;
    logic [7:0]  accum_reg, accum_next;
    logic        m_valid_reg, m_valid_next;
    result_t     res_reg, res_next;

    logic        pp_now;
    logic        rp_now;
    logic [10:0] rem_sum;
    logic        rem_carry;
    logic [9:0]  rem_c;
    logic [22:0] ms_sum;
    logic        wraps;
    logic [22:0] ms_add;
    logic [9:0]  rem_add;
    logic [16:0] done_limit;
    logic [7:0]  multi_accum;

    assign q_pop    = q_valid && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;
    assign m_result = res_reg;

    always_comb
    begin
        pp_now = press_pend_reg;
        rp_now = rel_pend_reg;
        if (q_item.press_edge)
        begin
            pp_now = 1'b1;
            rp_now = 1'b0;
        end
        else if (q_item.release_edge)
        begin
            pp_now = 1'b0;
            rp_now = 1'b1;
        end
    end

    always_comb
    begin
        rem_sum   = {1'b0, trem_reg} + {1'b0, cfg.period_rem_us};
        rem_carry = (rem_sum >= {1'b0, US_PER_MS});
        rem_c     = rem_carry ? 10'(rem_sum - {1'b0, US_PER_MS}) : rem_sum[9:0];
        ms_sum    = tms_reg + {16'd0, cfg.period_ms} + {22'd0, rem_carry};
        wraps     = (ms_sum > TIMER_WRAP_MS) ||
                    ((ms_sum == TIMER_WRAP_MS) && (rem_c >= TIMER_WRAP_US));
        ms_add    = ms_sum;
        rem_add   = rem_c;
        if (wraps)
        begin
            if (rem_c >= TIMER_WRAP_US)
            begin
                rem_add = rem_c - TIMER_WRAP_US;
                ms_add  = ms_sum - TIMER_WRAP_MS;
            end
            else
            begin
                rem_add = rem_c + WRAP_BORROW_US;
                ms_add  = ms_sum - TIMER_WRAP_MS - 23'd1;
            end
        end
        done_limit = {1'b0, cfg.long_click_ms} + {1'b0, cfg.multi_click_ms};
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            CLS_WAIT:
            begin
                if ((accum_reg != '0) && q_item.watched_level &&
                    (ms_add > {6'd0, done_limit}))
                begin
                    st_next = CLS_DONE;
                end
                if (pp_now)
                begin
                    st_next = CLS_PRESS;
                end
                if (rp_now)
                begin
                    st_next = CLS_RELEASE;
                end
            end
            CLS_RELEASE:
            begin
                if ((held_reg < {7'd0, cfg.multi_click_ms}) &&
                    ((accum_reg == '0) || (accum_reg > MULTI_LIMIT)))
                begin
                    st_next = CLS_MULTI;
                end
                else if (held_reg < {7'd0, cfg.long_click_ms})
                begin
                    st_next = CLS_SHORT;
                end
                else
                begin
                    st_next = CLS_LONG;
                end
            end
            CLS_PRESS, CLS_MULTI, CLS_SHORT, CLS_LONG, CLS_DONE:
            begin
                st_next = CLS_WAIT;
            end
            default:
            begin
                st_next = CLS_WAIT;
            end
        endcase
    end

    always_comb
    begin
        press_pend_next = pp_now;
        rel_pend_next   = rp_now;
        tms_next        = ms_add;
        trem_next       = rem_add;
        held_next       = held_reg;
        accum_next      = accum_reg;
        multi_accum     = accum_reg | MULTI_MARKER;
        res_next.debounced_bits = q_item.debounced;
        res_next.press_seen     = q_item.press_edge;
        res_next.release_seen   = q_item.release_edge;
        res_next.code_valid     = 1'b0;
        res_next.click_code     = '0;
        unique case (st_reg)
            CLS_WAIT:
            begin
                held_next = ms_add;
                if (pp_now || rp_now)
                begin
                    tms_next        = '0;
                    trem_next       = '0;
                    press_pend_next = 1'b0;
                    rel_pend_next   = 1'b0;
                end
            end
            CLS_MULTI:
            begin
                accum_next = multi_accum;
                if (multi_accum[3:0] != NIBBLE_FULL)
                begin
                    accum_next = multi_accum + 8'd1;
                end
            end
            CLS_SHORT:
            begin
                if (accum_reg[3:0] != NIBBLE_FULL)
                begin
                    accum_next = accum_reg + 8'd1;
                end
            end
            CLS_LONG:
            begin
                if (accum_reg[7:5] != LONG_FULL)
                begin
                    accum_next = accum_reg + LONG_STEP;
                end
            end
            CLS_DONE:
            begin
                accum_next          = '0;
                res_next.code_valid = (accum_reg != '0);
                res_next.click_code = accum_reg;
            end
            CLS_PRESS, CLS_RELEASE:
            begin
                accum_next = accum_reg;
            end
            default:
            begin
                accum_next = accum_reg;
            end
        endcase
        res_next.elapsed_ms = tms_next;
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (q_pop)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= CLS_WAIT;
            press_pend_reg <= 1'b0;
            rel_pend_reg   <= 1'b0;
            tms_reg        <= '0;
            trem_reg       <= '0;
            held_reg       <= '0;
            accum_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            if (q_pop)
            begin
                st_reg         <= st_next;
                press_pend_reg <= press_pend_next;
                rel_pend_reg   <= rel_pend_next;
                tms_reg        <= tms_next;
                trem_reg       <= trem_next;
                held_reg       <= held_next;
                accum_reg      <= accum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            res_reg <= res_next;
        end
    end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the button debounce and click coder. Raw button
// samples go in on the slave stream and every result on the master stream is
// compared, field by field, with an in-bench model of the debouncer, the
// microsecond timer and the click classifier. A short table of directed
// samples and register writes runs first. Random phases with fresh settings
// and press/release gestures follow, and a steady run at the largest sample
// period with no idling closes the test.
// ----------------------------------------------------------------------------
module testbench;
    import bdcc_pkg::*;

    localparam int ClkHalf      = 5;
    localparam int ResetCycles  = 5;
    localparam int SettleCycles = 8;
    localparam int CycleLimit   = 400000;
    localparam int PhaseItems   = 100;
    localparam int RandomPhases = 8;
    localparam int SteadyItems  = 120;
    localparam int PrintLimit   = 100;

    typedef struct {
        logic        byte_mode;
        logic        invert_input;
        logic [2:0]  watched_bit;
        logic [15:0] sample_period_us;
        logic [15:0] long_click_ms;
        logic [15:0] multi_click_ms;
    } settings_t;

    typedef enum logic {
        ROW_SAMPLE,
        ROW_WRITE
    } row_kind_t;

    typedef struct {
        row_kind_t                kind;
        logic [CfgIndexWidth-1:0] reg_index;
        logic [15:0]              value;
        logic                     typed;
        result_t                  want;
    } stim_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CfgIndexWidth-1:0] cfg_index;
    logic [CfgDataWidth-1:0]  cfg_wdata;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [7:0]               s_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [47:0]              m_tdata;

    settings_t   btn_cfg;
    logic [7:0]  smp_prev;
    logic [7:0]  smp_older;
    logic [7:0]  deb_level;
    logic        press_due;
    logic        release_due;
    logic [31:0] us_count;
    int unsigned held_count_ms;
    cls_state_t  coder_state;
    logic [7:0]  code_acc;

    result_t     tick_results_due[$];
    stim_row_t   stim_rows[$];
    logic [7:0]  noise_bits;
    logic        idle_on;
    int          mismatches;
    int          cycle_count;

    button_debounce_click_coder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #ClkHalf clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < PrintLimit)
            $display("MISMATCH %s: got 0x%0h, want 0x%0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic result_t typed_result(input logic [7:0] deb, input logic press,
                                             input logic rel, input logic [22:0] ms);
        result_t r;
        r = '0;
        r.debounced_bits = deb;
        r.press_seen     = press;
        r.release_seen   = rel;
        r.elapsed_ms     = ms;
        return r;
    endfunction

    // One sample tick of the debouncer, timer and click classifier.
    task automatic compute_tick_result(input logic [7:0] raw, output result_t r);
        logic [7:0]  cur;
        logic [7:0]  old_level;
        int unsigned wb;
        int unsigned width;
        int unsigned i;
        logic        pressed;
        logic        released;
        logic        emit;
        logic [7:0]  code;
        cur       = btn_cfg.byte_mode ? raw : {6'b0, raw[1:0]};
        if (btn_cfg.invert_input)
            cur = ~cur;
        old_level = deb_level;
        wb        = btn_cfg.watched_bit;
        width     = btn_cfg.byte_mode ? 8 : 2;
        pressed   = 1'b0;
        released  = 1'b0;
        emit      = 1'b0;
        code      = '0;

        for (i = wb; i < wb + width && i < 8; i++)
        begin
            if (cur[i] && smp_prev[i] && smp_older[i])
                deb_level[i] = 1'b1;
            else if (!cur[i] && !smp_prev[i] && !smp_older[i])
                deb_level[i] = 1'b0;
        end

        if (old_level[wb] && !deb_level[wb])
        begin
            pressed     = 1'b1;
            press_due   = 1'b1;
            release_due = 1'b0;
        end
        else if (!old_level[wb] && deb_level[wb])
        begin
            released    = 1'b1;
            release_due = 1'b1;
            press_due   = 1'b0;
        end
        smp_older = smp_prev;
        smp_prev  = cur;

        us_count = us_count + {16'b0, btn_cfg.sample_period_us};

        case (coder_state)
            CLS_WAIT:
            begin
                held_count_ms = us_count / 32'd1000;
                if (code_acc != 0 && deb_level[wb] &&
                    held_count_ms > int'(btn_cfg.long_click_ms) + int'(btn_cfg.multi_click_ms))
                    coder_state = CLS_DONE;
                if (press_due || release_due)
                    us_count = '0;
                if (press_due)
                begin
                    press_due   = 1'b0;
                    coder_state = CLS_PRESS;
                end
                if (release_due)
                begin
                    release_due = 1'b0;
                    coder_state = CLS_RELEASE;
                end
            end
            CLS_PRESS:
                coder_state = CLS_WAIT;
            CLS_RELEASE:
            begin
                if (held_count_ms < btn_cfg.multi_click_ms &&
                    (code_acc == 0 || code_acc > MULTI_LIMIT))
                    coder_state = CLS_MULTI;
                else if (held_count_ms < btn_cfg.long_click_ms)
                    coder_state = CLS_SHORT;
                else
                    coder_state = CLS_LONG;
            end
            CLS_MULTI:
            begin
                code_acc = code_acc | MULTI_MARKER;
                if (code_acc[3:0] < NIBBLE_FULL)
                    code_acc = code_acc + 8'd1;
                coder_state = CLS_WAIT;
            end
            CLS_SHORT:
            begin
                if (code_acc[3:0] < NIBBLE_FULL)
                    code_acc = code_acc + 8'd1;
                coder_state = CLS_WAIT;
            end
            CLS_LONG:
            begin
                if (code_acc[7:5] < LONG_FULL)
                    code_acc = code_acc + LONG_STEP;
                coder_state = CLS_WAIT;
            end
            CLS_DONE:
            begin
                code        = code_acc;
                code_acc    = '0;
                coder_state = CLS_WAIT;
                emit        = (code != 0);
            end
            default:
                coder_state = CLS_WAIT;
        endcase

        r                = '0;
        r.debounced_bits = deb_level;
        r.press_seen     = pressed;
        r.release_seen   = released;
        r.elapsed_ms     = 23'(us_count / 32'd1000);
        r.code_valid     = emit;
        r.click_code     = emit ? code : 8'h00;
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_sample(input logic [7:0] raw, input logic typed, input result_t want);
        result_t r;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= raw;
        do
            @(posedge clk);
        while (!s_tready);
        compute_tick_result(raw, r);
        tick_results_due.push_back(typed ? want : r);
        @(negedge clk);
    endtask

    task automatic stop_and_drain();
        s_tvalid <= 1'b0;
        while (tick_results_due.size() != 0)
            @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_BYTE_MODE:        btn_cfg.byte_mode        = val[0];
            CFG_INVERT_INPUT:     btn_cfg.invert_input     = val[0];
            CFG_WATCHED_BIT:      btn_cfg.watched_bit      = val[2:0];
            CFG_SAMPLE_PERIOD_US: btn_cfg.sample_period_us = val;
            CFG_LONG_CLICK_MS:    btn_cfg.long_click_ms    = val;
            CFG_MULTI_CLICK_MS:   btn_cfg.multi_click_ms   = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic apply_settings(input settings_t s);
        write_reg(CFG_BYTE_MODE, {15'b0, s.byte_mode});
        write_reg(CFG_INVERT_INPUT, {15'b0, s.invert_input});
        write_reg(CFG_WATCHED_BIT, {13'b0, s.watched_bit});
        write_reg(CFG_SAMPLE_PERIOD_US, s.sample_period_us);
        write_reg(CFG_LONG_CLICK_MS, s.long_click_ms);
        write_reg(CFG_MULTI_CLICK_MS, s.multi_click_ms);
    endtask

    function automatic int ticks_for_ms(input int unsigned ms);
        longint t;
        if (btn_cfg.sample_period_us == 0)
            return 40;
        t = longint'(ms) * 1000 / btn_cfg.sample_period_us + 1;
        return (t > 60) ? 60 : int'(t);
    endfunction

    // Holds the watched pin (or pin 0/1) at one level with a rare one-tick bounce.
    task automatic send_level_run(input logic level, input int ticks);
        logic [2:0] pos;
        logic [7:0] raw;
        repeat (ticks)
        begin
            if ($urandom_range(0, 3) == 0)
                noise_bits = 8'($urandom);
            if (btn_cfg.byte_mode || btn_cfg.watched_bit < 3'd2)
                pos = btn_cfg.watched_bit;
            else
                pos = 3'($urandom_range(0, 1));
            raw      = noise_bits;
            raw[pos] = level ^ btn_cfg.invert_input ^ ($urandom_range(0, 9) == 0);
            send_sample(raw, 1'b0, '0);
        end
    endtask

    initial
    begin
        int stall;
        m_tready = 1'b0;
        stall    = 0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                stall--;
                m_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 8) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata[41:0]);
            if (m_tdata[47:42] != 0)
                report_mismatch("padding", 32'(m_tdata[47:42]), 0);
            if (tick_results_due.size() == 0)
                report_mismatch("result with none due", 32'(got), 0);
            else
            begin
                want = tick_results_due.pop_front();
                if (got.debounced_bits != want.debounced_bits)
                    report_mismatch("debounced_bits", 32'(got.debounced_bits),
                                    32'(want.debounced_bits));
                if (got.press_seen != want.press_seen)
                    report_mismatch("press_seen", 32'(got.press_seen), 32'(want.press_seen));
                if (got.release_seen != want.release_seen)
                    report_mismatch("release_seen", 32'(got.release_seen),
                                    32'(want.release_seen));
                if (got.elapsed_ms != want.elapsed_ms)
                    report_mismatch("elapsed_ms", 32'(got.elapsed_ms), 32'(want.elapsed_ms));
                if (got.code_valid != want.code_valid)
                    report_mismatch("code_valid", 32'(got.code_valid), 32'(want.code_valid));
                if (got.click_code != want.click_code)
                    report_mismatch("click_code", 32'(got.click_code), 32'(want.click_code));
            end
        end
    end

    initial
    begin
        settings_t  s;
        int         p;
        int         sent;
        int         n;
        int         press_ticks;
        int         gap_ticks;
        int         unit_ms;
        logic [7:0] hold_raw;

        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        idle_on     = 1'b1;
        mismatches  = 0;
        cycle_count = 0;
        noise_bits  = '0;

        btn_cfg.byte_mode        = 1'b0;
        btn_cfg.invert_input     = 1'b0;
        btn_cfg.watched_bit      = '0;
        btn_cfg.sample_period_us = RESET_SAMPLE_PERIOD_US;
        btn_cfg.long_click_ms    = RESET_LONG_CLICK_MS;
        btn_cfg.multi_click_ms   = RESET_MULTI_CLICK_MS;
        smp_prev      = '0;
        smp_older     = '0;
        deb_level     = '0;
        press_due     = 1'b0;
        release_due   = 1'b0;
        us_count      = '0;
        held_count_ms = 0;
        coder_state   = CLS_WAIT;
        code_acc      = '0;

        // Reset settings: 5 ms per tick, two pins, watched bit zero.
        stim_rows.push_back('{ROW_SAMPLE, '0, 16'h0000, 1'b1,
                              typed_result(8'h00, 1'b0, 1'b0, 23'd5)});
        stim_rows.push_back('{ROW_SAMPLE, '0, 16'h0000, 1'b1,
                              typed_result(8'h00, 1'b0, 1'b0, 23'd10)});
        stim_rows.push_back('{ROW_SAMPLE, '0, 16'h00FF, 1'b1,
                              typed_result(8'h00, 1'b0, 1'b0, 23'd15)});
        stim_rows.push_back('{ROW_SAMPLE, '0, 16'h00FF, 1'b1,
                              typed_result(8'h00, 1'b0, 1'b0, 23'd20)});
        stim_rows.push_back('{ROW_SAMPLE, '0, 16'h00FF, 1'b1,
                              typed_result(8'h03, 1'b0, 1'b1, 23'd0)});
        stim_rows.push_back('{ROW_SAMPLE, '0, 16'h00FF, 1'b0, '0});
        stim_rows.push_back('{ROW_SAMPLE, '0, 16'h0000, 1'b0, '0});
        stim_rows.push_back('{ROW_SAMPLE, '0, 16'h0000, 1'b0, '0});
        stim_rows.push_back('{ROW_SAMPLE, '0, 16'h0000, 1'b0, '0});
        stim_rows.push_back('{ROW_SAMPLE, '0, 16'h00FF, 1'b0, '0});
        stim_rows.push_back('{ROW_SAMPLE, '0, 16'h00FF, 1'b0, '0});
        stim_rows.push_back('{ROW_SAMPLE, '0, 16'h00FF, 1'b0, '0});
        // Byte mode, inverted, window at the top bit, largest period, zero thresholds.
        stim_rows.push_back('{ROW_WRITE, CFG_BYTE_MODE, 16'h0001, 1'b0, '0});
        stim_rows.push_back('{ROW_WRITE, CFG_INVERT_INPUT, 16'h0001, 1'b0, '0});
        stim_rows.push_back('{ROW_WRITE, CFG_WATCHED_BIT, 16'h0007, 1'b0, '0});
        stim_rows.push_back('{ROW_WRITE, CFG_SAMPLE_PERIOD_US, 16'hFFFF, 1'b0, '0});
        stim_rows.push_back('{ROW_WRITE, CFG_LONG_CLICK_MS, 16'h0000, 1'b0, '0});
        stim_rows.push_back('{ROW_WRITE, CFG_MULTI_CLICK_MS, 16'h0000, 1'b0, '0});
        stim_rows.push_back('{ROW_SAMPLE, '0, 16'h0000, 1'b0, '0});
        stim_rows.push_back('{ROW_SAMPLE, '0, 16'h0000, 1'b0, '0});
        stim_rows.push_back('{ROW_SAMPLE, '0, 16'h0000, 1'b0, '0});
        stim_rows.push_back('{ROW_SAMPLE, '0, 16'h00FF, 1'b0, '0});
        stim_rows.push_back('{ROW_SAMPLE, '0, 16'h00FF, 1'b0, '0});
        stim_rows.push_back('{ROW_SAMPLE, '0, 16'h00FF, 1'b0, '0});
        stim_rows.push_back('{ROW_SAMPLE, '0, 16'h0080, 1'b0, '0});
        stim_rows.push_back('{ROW_SAMPLE, '0, 16'h007F, 1'b0, '0});
        // Two pins with the window above them, period zero, largest thresholds.
        stim_rows.push_back('{ROW_WRITE, CFG_BYTE_MODE, 16'h0000, 1'b0, '0});
        stim_rows.push_back('{ROW_WRITE, CFG_INVERT_INPUT, 16'h0000, 1'b0, '0});
        stim_rows.push_back('{ROW_WRITE, CFG_WATCHED_BIT, 16'h0005, 1'b0, '0});
        stim_rows.push_back('{ROW_WRITE, CFG_SAMPLE_PERIOD_US, 16'h0000, 1'b0, '0});
        stim_rows.push_back('{ROW_WRITE, CFG_LONG_CLICK_MS, 16'hFFFF, 1'b0, '0});
        stim_rows.push_back('{ROW_WRITE, CFG_MULTI_CLICK_MS, 16'hFFFF, 1'b0, '0});
        stim_rows.push_back('{ROW_SAMPLE, '0, 16'h00FF, 1'b0, '0});
        stim_rows.push_back('{ROW_SAMPLE, '0, 16'h0055, 1'b0, '0});
        stim_rows.push_back('{ROW_SAMPLE, '0, 16'h00AA, 1'b0, '0});
        stim_rows.push_back('{ROW_SAMPLE, '0, 16'h0000, 1'b0, '0});
        stim_rows.push_back('{ROW_SAMPLE, '0, 16'h00FF, 1'b0, '0});

        repeat (ResetCycles) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (stim_rows[k])
        begin
            if (stim_rows[k].kind == ROW_WRITE)
            begin
                stop_and_drain();
                write_reg(stim_rows[k].reg_index, stim_rows[k].value);
            end
            else
                send_sample(stim_rows[k].value[7:0], stim_rows[k].typed, stim_rows[k].want);
        end

        for (p = 0; p < RandomPhases; p++)
        begin
            stop_and_drain();
            if (p == 0)
                s = '{1'b0, 1'b0, 3'd0, 16'd0, 16'd0, 16'd0};
            else if (p == 1)
                s = '{1'b1, 1'b1, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF};
            else
            begin
                s.byte_mode    = 1'($urandom_range(0, 1));
                s.invert_input = 1'($urandom_range(0, 1));
                if (!s.byte_mode && $urandom_range(0, 3) != 0)
                    s.watched_bit = 3'($urandom_range(0, 1));
                else
                    s.watched_bit = 3'($urandom_range(0, 7));
                s.sample_period_us = 16'($urandom_range(1000, 65535));
                unit_ms            = s.sample_period_us / 1000;
                s.long_click_ms    = 16'(unit_ms * $urandom_range(3, 15));
                s.multi_click_ms   = 16'(unit_ms * $urandom_range(1, 8));
            end
            apply_settings(s);
            idle_on = ($urandom_range(0, 3) != 0);

            sent = 0;
            while (sent < PhaseItems)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    press_ticks = $urandom_range(1, ticks_for_ms(btn_cfg.long_click_ms) + 3);
                    if ($urandom_range(0, 1) == 0)
                        gap_ticks = $urandom_range(1, ticks_for_ms(btn_cfg.multi_click_ms) + 3);
                    else
                        gap_ticks = ticks_for_ms(int'(btn_cfg.long_click_ms) +
                                                 int'(btn_cfg.multi_click_ms)) +
                                    $urandom_range(2, 6);
                    send_level_run(1'b0, press_ticks);
                    send_level_run(1'b1, gap_ticks);
                    sent += press_ticks + gap_ticks;
                end
                else
                begin
                    n = $urandom_range(1, 6);
                    repeat (n) send_sample(8'($urandom), 1'b0, '0);
                    sent += n;
                end
            end
        end

        // Steady input at the largest sample period, with no idling on either side.
        stop_and_drain();
        idle_on            = 1'b0;
        s.byte_mode        = 1'($urandom_range(0, 1));
        s.invert_input     = 1'($urandom_range(0, 1));
        s.watched_bit      = 3'($urandom_range(0, 7));
        s.sample_period_us = 16'hFFFF;
        s.long_click_ms    = 16'($urandom_range(0, 65535));
        s.multi_click_ms   = 16'($urandom_range(0, 65535));
        apply_settings(s);
        hold_raw = 8'($urandom);
        repeat (SteadyItems) send_sample(hold_raw, 1'b0, '0);

        stop_and_drain();
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
